// File: src/in_order_segment_receiver_unit_macros.svh
// Assertion macros for the in-order segment receiver.
`ifndef IN_ORDER_SEGMENT_RECEIVER_UNIT_MACROS_SVH
`define IN_ORDER_SEGMENT_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IOSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("iosr: assertion failed");
`define IOSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("iosr: assertion failed");
`else
`define IOSR_ASSERT(lbl, prop)
`define IOSR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: src/iosr_pkg.sv
package iosr_pkg;

  localparam int unsigned BUFFER_BYTES = 65536;
  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned CNT_W  = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned SUM_W  = ((CNT_W > 16) ? CNT_W : 16) + 1;

  localparam logic [15:0] WINDOW_CAP     = 16'hFFFF;
  localparam logic [3:0]  FINACK_DEFAULT = 4'd5;
  localparam logic [3:0]  FINACK_MAX     = 4'd8;
  localparam logic [6:0]  READ_CAP       = 7'd64;

  localparam logic [1:0] SEG_DATA = 2'd0;
  localparam logic [1:0] SEG_FIN  = 2'd1;

  localparam logic [1:0] CFG_PROTO  = 2'd0;
  localparam logic [1:0] CFG_CONN   = 2'd1;
  localparam logic [1:0] CFG_FINREP = 2'd2;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_READ    = 2'd3
  } in_kind_e;

  typedef enum logic [2:0] {
    RK_ACK    = 3'd0,
    RK_FINACK = 3'd1,
    RK_BYTE   = 3'd2,
    RK_EMPTY  = 3'd3,
    RK_EOS    = 3'd4
  } reply_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_FIN  = 3'b010,
    ST_READ = 3'b100
  } state_e;

  function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] ptr);
    ring_next = (ptr == ADDR_W'(BUFFER_BYTES - 1)) ? '0 : ptr + 1'b1;
  endfunction

  // Free space after the bytes still due, saturated to 16 bits.
  function automatic logic [15:0] window(input logic [CNT_W-1:0] stored,
                                         input logic [15:0] due);
    logic [SUM_W-1:0] used;
    logic [SUM_W-1:0] free;
    used = SUM_W'(stored) + SUM_W'(due);
    free = (used >= SUM_W'(BUFFER_BYTES)) ? '0 : SUM_W'(BUFFER_BYTES) - used;
    window = (free > SUM_W'(WINDOW_CAP)) ? WINDOW_CAP : free[15:0];
  endfunction

endpackage

// File: src/in_order_segment_receiver_unit.sv
// In-order segment receiver for one connection. Input transfers carry a kind in
// s_axis_tuser: segment header, payload byte, timeout tick or read request. A data
// header with the expected protocol code answers with one ACK; a FIN header answers
// with finack_repeats FINACKs, one per cycle while the output is not stalled; a timeout
// re-sends the ACK. Payload bytes are taken one per cycle while nothing stalls, and written to
// a 64 KiB byte ring. A read request returns up to read_max (1 to 64) stored bytes, one
// byte per cycle while the output is not stalled, since a single memory read port feeds
// the output. The next input is taken once the last result of the current one sits in
// the output register; a stalled master side holds everything. Configuration writes are
// taken at any time and should be done while no traffic is in flight.
`include "in_order_segment_receiver_unit_macros.svh"

module in_order_segment_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] protocol_code, [9:8] segment_type, [25:10] seq_number,
  // [41:26] payload_length, [49:42] payload_byte, [56:50] read_max
  input  logic [63:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] connection_id, [23:8] ack_number, [39:24] receive_window,
  // [47:40] data_byte
  output logic [47:0] m_axis_tdata,
  // [2:0] reply_kind
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned AW = iosr_pkg::ADDR_W;
  localparam int unsigned CW = iosr_pkg::CNT_W;

  // configuration
  logic [7:0] exp_proto_q, conn_q;
  logic [3:0] finrep_q;

  // connection state
  iosr_pkg::state_e state_q, state_d;
  logic [AW-1:0] head_q, head_d, wp_q, wp_d;
  logic [CW-1:0] stored_q, stored_d;
  logic [15:0]   exp_seq_q, exp_seq_d, left_q, left_d;
  logic          acc_q, acc_d, done_q, done_d;
  logic [3:0]    fin_cnt_q, fin_cnt_d;
  logic [6:0]    rd_cnt_q, rd_cnt_d;

  // output register
  logic        m_valid_q, m_valid_d;
  iosr_pkg::reply_kind_e o_kind_q, o_kind_d;
  logic [7:0]  o_conn_q, o_conn_d, o_byte_q, o_byte_d;
  logic [15:0] o_ack_q, o_ack_d, o_win_q, o_win_d;
  logic        o_last_q, o_last_d;
  logic        out_load;

  // memory
  logic [7:0] mem [iosr_pkg::BUFFER_BYTES];
  logic [7:0] rd_data_q;
  logic       mem_we;

  // input decode
  iosr_pkg::in_kind_e in_kind;
  logic [7:0]  in_proto, in_pbyte;
  logic [1:0]  in_stype;
  logic [15:0] in_seq, in_plen;
  logic [6:0]  in_rmax, rmax_c;
  logic [3:0]  fin_n;
  logic        in_acc, out_free;
  logic [iosr_pkg::SUM_W-1:0] fill_sum;

  assign in_kind  = iosr_pkg::in_kind_e'(s_axis_tuser);
  assign in_proto = s_axis_tdata[7:0];
  assign in_stype = s_axis_tdata[9:8];
  assign in_seq   = s_axis_tdata[25:10];
  assign in_plen  = s_axis_tdata[41:26];
  assign in_pbyte = s_axis_tdata[49:42];
  assign in_rmax  = s_axis_tdata[56:50];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == iosr_pkg::ST_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign rmax_c = (in_rmax == 7'd0) ? 7'd1 :
                  (in_rmax > iosr_pkg::READ_CAP) ? iosr_pkg::READ_CAP : in_rmax;
  assign fin_n  = (finrep_q == 4'd0) ? 4'd1 :
                  (finrep_q > iosr_pkg::FINACK_MAX) ? iosr_pkg::FINACK_MAX : finrep_q;
  assign fill_sum = iosr_pkg::SUM_W'(stored_q) + iosr_pkg::SUM_W'(in_plen);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    wp_d      = wp_q;
    stored_d  = stored_q;
    exp_seq_d = exp_seq_q;
    left_d    = left_q;
    acc_d     = acc_q;
    done_d    = done_q;
    fin_cnt_d = fin_cnt_q;
    rd_cnt_d  = rd_cnt_q;
    mem_we    = 1'b0;
    out_load  = 1'b0;
    o_kind_d  = iosr_pkg::RK_ACK;
    o_conn_d  = '0;
    o_ack_d   = '0;
    o_win_d   = '0;
    o_byte_d  = '0;
    o_last_d  = 1'b1;

    case (state_q)
      iosr_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            iosr_pkg::KIND_HEADER: begin
              // any header ends the current segment
              left_d = '0;
              acc_d  = 1'b0;
              if (in_proto == exp_proto_q) begin
                if (in_stype == iosr_pkg::SEG_DATA) begin
                  left_d = in_plen;
                  if (in_seq == exp_seq_q &&
                      fill_sum <= iosr_pkg::SUM_W'(iosr_pkg::BUFFER_BYTES)) begin
                    acc_d     = 1'b1;
                    exp_seq_d = exp_seq_q + 16'd1;
                  end
                  out_load = 1'b1;
                  o_kind_d = iosr_pkg::RK_ACK;
                  o_conn_d = conn_q;
                  o_ack_d  = exp_seq_d;
                  o_win_d  = iosr_pkg::window(stored_q, acc_d ? in_plen : 16'd0);
                end else if (in_stype == iosr_pkg::SEG_FIN) begin
                  done_d   = 1'b1;
                  out_load = 1'b1;
                  o_kind_d = iosr_pkg::RK_FINACK;
                  o_conn_d = conn_q;
                  o_last_d = (fin_n == 4'd1);
                  if (fin_n != 4'd1) begin
                    fin_cnt_d = fin_n - 4'd1;
                    state_d   = iosr_pkg::ST_FIN;
                  end
                end
              end
            end
            iosr_pkg::KIND_PAYLOAD: begin
              if (left_q != 16'd0) begin
                left_d = left_q - 16'd1;
                if (acc_q && stored_q < CW'(iosr_pkg::BUFFER_BYTES)) begin
                  mem_we   = 1'b1;
                  wp_d     = iosr_pkg::ring_next(wp_q);
                  stored_d = stored_q + 1'b1;
                end
                if (left_d == 16'd0) begin
                  acc_d = 1'b0;
                end
              end
            end
            iosr_pkg::KIND_TIMEOUT: begin
              out_load = 1'b1;
              o_kind_d = iosr_pkg::RK_ACK;
              o_conn_d = conn_q;
              o_ack_d  = exp_seq_q;
              o_win_d  = iosr_pkg::window(stored_q, acc_q ? left_q : 16'd0);
            end
            iosr_pkg::KIND_READ: begin
              if (stored_q == '0) begin
                out_load = 1'b1;
                o_kind_d = done_q ? iosr_pkg::RK_EOS : iosr_pkg::RK_EMPTY;
              end else begin
                rd_cnt_d = (stored_q < CW'(rmax_c)) ? stored_q[6:0] : rmax_c;
                state_d  = iosr_pkg::ST_READ;
              end
            end
            default: begin
              state_d = iosr_pkg::ST_IDLE;
            end
          endcase
        end
      end
      iosr_pkg::ST_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          o_kind_d  = iosr_pkg::RK_FINACK;
          o_conn_d  = conn_q;
          o_last_d  = (fin_cnt_q == 4'd1);
          fin_cnt_d = fin_cnt_q - 4'd1;
          if (fin_cnt_q == 4'd1) begin
            state_d = iosr_pkg::ST_IDLE;
          end
        end
      end
      iosr_pkg::ST_READ: begin
        // rd_data_q always holds the byte at head_q here
        if (out_free) begin
          out_load = 1'b1;
          o_kind_d = iosr_pkg::RK_BYTE;
          o_byte_d = rd_data_q;
          o_last_d = (rd_cnt_q == 7'd1);
          head_d   = iosr_pkg::ring_next(head_q);
          stored_d = stored_q - 1'b1;
          rd_cnt_d = rd_cnt_q - 7'd1;
          if (rd_cnt_q == 7'd1) begin
            state_d = iosr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = iosr_pkg::ST_IDLE;
      end
    endcase
  end

  assign m_valid_d = out_load || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_proto_q <= '0;
      conn_q      <= '0;
      finrep_q    <= iosr_pkg::FINACK_DEFAULT;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        iosr_pkg::CFG_PROTO:  exp_proto_q <= cfg_wdata_i;
        iosr_pkg::CFG_CONN:   conn_q      <= cfg_wdata_i;
        iosr_pkg::CFG_FINREP: finrep_q    <= cfg_wdata_i[3:0];
        default: begin
          // unmapped index: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= iosr_pkg::ST_IDLE;
      head_q    <= '0;
      wp_q      <= '0;
      stored_q  <= '0;
      exp_seq_q <= '0;
      left_q    <= '0;
      acc_q     <= 1'b0;
      done_q    <= 1'b0;
      fin_cnt_q <= '0;
      rd_cnt_q  <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      wp_q      <= wp_d;
      stored_q  <= stored_d;
      exp_seq_q <= exp_seq_d;
      left_q    <= left_d;
      acc_q     <= acc_d;
      done_q    <= done_d;
      fin_cnt_q <= fin_cnt_d;
      rd_cnt_q  <= rd_cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_kind_q <= o_kind_d;
      o_conn_q <= o_conn_d;
      o_ack_q  <= o_ack_d;
      o_win_q  <= o_win_d;
      o_byte_q <= o_byte_d;
      o_last_q <= o_last_d;
    end
  end

  // Byte ring: one write port, one registered read port addressed by the next head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= in_pbyte;
    end
    rd_data_q <= mem[head_d];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {o_byte_q, o_win_q, o_ack_q, o_conn_q};
  assign m_axis_tuser  = o_kind_q;
  assign m_axis_tlast  = o_last_q;

  `IOSR_ASSERT(a_stored_bound, stored_q <= CW'(iosr_pkg::BUFFER_BYTES))
  `IOSR_ASSERT(a_read_count, (state_q != iosr_pkg::ST_READ) || (rd_cnt_q != 7'd0 && CW'(rd_cnt_q) <= stored_q))
  `IOSR_ASSERT(a_fin_count, (state_q != iosr_pkg::ST_FIN) || (fin_cnt_q != 4'd0))
  `IOSR_ASSERT(a_no_overwrite, !out_load || out_free)
  `IOSR_ASSERT_NEXT(a_store_grows, mem_we, stored_q == $past(stored_q) + 1'b1)

endmodule
